>>> rtl/constant_velocity_kalman_filter_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef CONSTANT_VELOCITY_KALMAN_FILTER_ASSERT_SVH
`define CONSTANT_VELOCITY_KALMAN_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CVKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CVKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cvkf_pkg.sv
`timescale 1ns / 1ps

package cvkf_pkg;

  localparam int COV_FRAC_BITS = 24;
  localparam int DATA_W        = 32;
  localparam int NOISE_W       = 25;
  localparam int CFG_IDX_W     = 2;
  localparam int DEN_W         = DATA_W + 2;
  localparam int WIDE_W        = 42;
  localparam int RND_W         = 2 * DATA_W - COV_FRAC_BITS;
  localparam int DIV_W         = DATA_W + COV_FRAC_BITS;
  localparam int CNT_W         = $clog2(DIV_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = NOISE_W'(1678);
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = NOISE_W'(167772);
  localparam logic signed [DATA_W-1:0] COV_ONE = DATA_W'(1) << COV_FRAC_BITS;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX =
    {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN =
    {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED0, ST_PRED1, ST_ERR, ST_DIV_GO, ST_DIV_WAIT,
    ST_MUL_GO, ST_MUL_WAIT, ST_APPLY, ST_OUT
  } state_t;

  // Which state element the current multiply updates.
  typedef enum logic [2:0] {
    UPD_POS, UPD_VEL, UPD_C00, UPD_C01, UPD_C10, UPD_C11
  } upd_t;

  typedef enum logic {OP_MUL, OP_DIV} unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  // Sign-extend a data word to the wide sum width.
  function automatic logic signed [WIDE_W-1:0] sext(input logic signed [DATA_W-1:0] v);
    return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // Clamp a wide sum to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[DATA_W-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cvkf_if.sv
`timescale 1ns / 1ps

// Range sample channel.
interface cvkf_sample_if;
  import cvkf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_sample;
  modport source (output valid, output range_sample, input ready);
  modport sink (input valid, input range_sample, output ready);
endinterface

// Filtered position channel.
interface cvkf_estimate_if;
  import cvkf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered_position;
  modport source (output valid, output filtered_position, input ready);
  modport sink (input valid, input filtered_position, output ready);
endinterface

>>> rtl/cvkf_serial_unit.sv
`timescale 1ns / 1ps

// Bit-serial multiplier and restoring divider sharing one shift register.
module cvkf_serial_unit
  import cvkf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  unit_req_t                req,
  input  logic signed [DATA_W-1:0] opa,
  input  logic signed [DEN_W-1:0]  opb,
  output unit_rsp_t                rsp,
  output logic signed [2*DATA_W-1:0] prod,
  output logic signed [DATA_W-1:0] quot
);

  localparam logic [DIV_W-1:0] Q_LIM = DIV_W'(1) << (DATA_W - 1);

  logic                  busy;
  logic                  done;
  unit_op_t              op_r;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;
  logic [2*DATA_W-1:0]   acc;
  logic [DEN_W-1:0]      dvs;
  logic [DEN_W:0]        rem;

  logic [DATA_W-1:0]     mag_a;
  logic [DEN_W-1:0]      mag_b;
  logic [DEN_W+1:0]      div_t;
  logic                  div_ge;
  logic [DEN_W:0]        rem_next;
  logic [DATA_W:0]       mul_sum;
  logic [DIV_W-1:0]      qm;

  // Operand magnitudes; the sign of the result is kept apart.
  assign mag_a = opa[DATA_W-1] ? DATA_W'(-opa) : DATA_W'(opa);
  assign mag_b = opb[DEN_W-1] ? DEN_W'(-opb) : DEN_W'(opb);

  // One quotient bit per cycle.
  assign div_t    = {rem, acc[DIV_W-1]};
  assign div_ge   = div_t >= {2'b00, dvs};
  assign rem_next = div_ge ? (DEN_W+1)'(div_t - {2'b00, dvs}) : div_t[DEN_W:0];

  // One multiplier bit per cycle, shift-and-add into the upper half.
  assign mul_sum = {1'b0, acc[2*DATA_W-1:DATA_W]}
                 + (acc[0] ? {1'b0, dvs[DATA_W-1:0]} : {(DATA_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        neg  <= opa[DATA_W-1] ^ opb[DEN_W-1];
        rem  <= '0;
        if (req.op == OP_DIV) begin
          acc <= {{(2*DATA_W-DIV_W){1'b0}}, mag_a, {COV_FRAC_BITS{1'b0}}};
          dvs <= mag_b;
          cnt <= CNT_W'(DIV_W);
        end else begin
          acc <= {{DATA_W{1'b0}}, mag_b[DATA_W-1:0]};
          dvs <= {{(DEN_W-DATA_W){1'b0}}, mag_a};
          cnt <= CNT_W'(DATA_W);
        end
      end else if (busy) begin
        if (op_r == OP_DIV) begin
          rem <= rem_next;
          acc <= {acc[2*DATA_W-2:0], div_ge};
        end else begin
          acc <= {mul_sum, acc[DATA_W-1:1]};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Signed results: product as is, quotient clamped to the data range.
  assign qm   = acc[DIV_W-1:0];
  assign prod = neg ? -$signed(acc) : $signed(acc);

  always_comb begin
    if (neg) begin
      quot = (qm > Q_LIM) ? WIDE_MIN[DATA_W-1:0] : DATA_W'(-qm[DATA_W-1:0]);
    end else begin
      quot = (qm >= Q_LIM) ? WIDE_MAX[DATA_W-1:0] : qm[DATA_W-1:0];
    end
  end

  assign rsp = '{busy: busy, done: done};

endmodule

>>> rtl/constant_velocity_kalman_filter.sv
`timescale 1ns / 1ps

// Channel    | Dir | Payload
// samples    | in  | range_sample, signed Q16.16
// estimates  | out | filtered_position, signed Q16.16
// cfg_*      | in  | index 0 process noise, index 1 measurement noise, unsigned Q1.24
//
// The first sample after reset skips the update and goes straight out as the position.
// Later samples run two gain divisions (unless the divisor is zero) and six
// multiplies, all on the one bit-serial unit, plus sequencing.
// Reset is synchronous; it restores the initial state and noise values.
// A waiting result is held in the output register while the next sample runs.

module constant_velocity_kalman_filter
  import cvkf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  cvkf_sample_if.sink          samples,
  cvkf_estimate_if.source      estimates,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NOISE_W-1:0]   cfg_data
);

  state_t state, state_next;
  upd_t   upd;

  logic                     primed;
  logic signed [DATA_W-1:0] pos, vel, c00, c01, c10, c11;
  logic [NOISE_W-1:0]       q_noise, r_noise;
  logic signed [DATA_W-1:0] z, xp0, p00, p01, p10, p11, e, k0, k1;
  logic signed [DEN_W-1:0]  s;
  logic signed [RND_W-1:0]  rnd;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;

  unit_req_t                  req;
  unit_rsp_t                  rsp;
  logic signed [DATA_W-1:0]   opa;
  logic signed [DEN_W-1:0]    opb;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [DATA_W-1:0]   quot;

  logic signed [DATA_W-1:0] base;
  logic                     subtract;
  logic signed [WIDE_W-1:0] rnd_wide;
  logic signed [DATA_W-1:0] upd_value;
  logic signed [DATA_W-1:0] mul_val;

  cvkf_serial_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .rsp  (rsp),
    .prod (prod),
    .quot (quot)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= PROCESS_NOISE_RESET;
      r_noise <= MEASUREMENT_NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     q_noise <= cfg_data;
        REG_MEASUREMENT_NOISE: r_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand selection for the current multiply.
  always_comb begin
    case (upd)
      UPD_POS, UPD_VEL: mul_val = e;
      UPD_C00, UPD_C10: mul_val = p00;
      default:          mul_val = p01;
    endcase
  end

  // Next state and handshake/unit controls.
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    req           = '{start: 1'b0, op: OP_MUL};
    opa           = p00;
    opb           = s;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = primed ? ST_PRED0 : ST_OUT;
        end
      end
      ST_PRED0: state_next = ST_PRED1;
      ST_PRED1: state_next = ST_ERR;
      ST_ERR:   state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        if (s == '0) begin
          state_next = ST_MUL_GO;
        end else begin
          req        = '{start: 1'b1, op: OP_DIV};
          opa        = (upd == UPD_VEL) ? p10 : p00;
          opb        = s;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (rsp.done) begin
          state_next = (upd == UPD_VEL) ? ST_MUL_GO : ST_DIV_GO;
        end
      end
      ST_MUL_GO: begin
        req = '{start: 1'b1, op: OP_MUL};
        opa = (upd == UPD_VEL || upd == UPD_C10 || upd == UPD_C11) ? k1 : k0;
        opb = {{(DEN_W-DATA_W){mul_val[DATA_W-1]}}, mul_val};
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (rsp.done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: state_next = (upd == UPD_C11) ? ST_OUT : ST_MUL_GO;
      ST_OUT: begin
        if (!out_valid || estimates.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Base value and direction of the update being applied.
  always_comb begin
    subtract = 1'b1;
    case (upd)
      UPD_POS: begin base = xp0; subtract = 1'b0; end
      UPD_VEL: begin base = vel; subtract = 1'b0; end
      UPD_C00: base = p00;
      UPD_C01: base = p01;
      UPD_C10: base = p10;
      default: base = p11;
    endcase
  end

  assign rnd_wide  = {{(WIDE_W-RND_W){rnd[RND_W-1]}}, rnd};
  assign upd_value = sat32(subtract ? sext(base) - rnd_wide : sext(base) + rnd_wide);

  // Filter state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      pos    <= '0;
      vel    <= '0;
      c00    <= COV_ONE;
      c01    <= '0;
      c10    <= '0;
      c11    <= COV_ONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            z <= samples.range_sample;
            if (!primed) begin
              pos    <= samples.range_sample;
              vel    <= '0;
              primed <= 1'b1;
            end
          end
        end
        ST_PRED0: begin
          xp0 <= sat32(sext(pos) + sext(vel));
          s   <= DEN_W'(sext(c00) + sext(c01) + sext(c10));
          p01 <= sat32(sext(c01) + sext(c11));
          p10 <= sat32(sext(c10) + sext(c11));
          p11 <= sat32(sext(c11) + {{(WIDE_W-NOISE_W){1'b0}}, q_noise});
        end
        ST_PRED1: begin
          p00 <= sat32({{(WIDE_W-DEN_W){s[DEN_W-1]}}, s} + sext(c11)
                       + {{(WIDE_W-NOISE_W){1'b0}}, q_noise});
        end
        ST_ERR: begin
          e   <= sat32(sext(z) - sext(xp0));
          s   <= {{(DEN_W-DATA_W){p00[DATA_W-1]}}, p00}
               + {{(DEN_W-NOISE_W){1'b0}}, r_noise};
          upd <= UPD_POS;
        end
        ST_DIV_GO: begin
          // A zero divisor gives zero gains.
          if (s == '0) begin
            k0  <= '0;
            k1  <= '0;
            upd <= UPD_POS;
          end
        end
        ST_DIV_WAIT: begin
          if (rsp.done) begin
            if (upd == UPD_VEL) begin
              k1  <= quot;
              upd <= UPD_POS;
            end else begin
              k0  <= quot;
              upd <= UPD_VEL;
            end
          end
        end
        ST_MUL_WAIT: begin
          // Round to nearest, ties toward plus infinity.
          if (rsp.done) begin
            rnd <= RND_W'((prod + ((2*DATA_W)'(1) << (COV_FRAC_BITS - 1)))
                          >>> COV_FRAC_BITS);
          end
        end
        ST_APPLY: begin
          case (upd)
            UPD_POS: pos <= upd_value;
            UPD_VEL: vel <= upd_value;
            UPD_C00: c00 <= upd_value;
            UPD_C01: c01 <= upd_value;
            UPD_C10: c10 <= upd_value;
            default: c11 <= upd_value;
          endcase
          if (upd != UPD_C11) begin
            upd <= upd_t'(upd + 3'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || estimates.ready)) begin
      out_valid <= 1'b1;
      out_data  <= pos;
    end else if (estimates.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign estimates.valid             = out_valid;
  assign estimates.filtered_position = out_data;

  `include "constant_velocity_kalman_filter_assert.svh"

  `CVKF_ASSERT_NOW(a_start_idle_unit, req.start, !rsp.busy, "serial unit restarted while busy")
  `CVKF_ASSERT_NOW(a_done_in_wait, rsp.done, (state == ST_DIV_WAIT || state == ST_MUL_WAIT), "unit result with no wait")
  `CVKF_ASSERT_NEXT(a_first_sample, (samples.valid && samples.ready && !primed), (state == ST_OUT && primed), "first sample not passed straight out")
  `CVKF_ASSERT_NOW(a_out_hold, (state == ST_OUT && out_valid && !estimates.ready), (state_next == ST_OUT), "pending result overwritten")

endmodule

>>> sim/constant_velocity_kalman_filter_tb.sv
`timescale 1ns / 1ps

module constant_velocity_kalman_filter_tb;
  import cvkf_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 400;

  // Tracks the filter state and holds the positions it should emit.
  class position_scoreboard;
    bit          primed;
    int          pos_est;
    int          vel_est;
    int          cov [4];
    int          q_noise;
    int          r_noise;
    int          expected_pos [$];
    int          mismatches;
    int          samples_seen;
    int          results_seen;
    int          zero_div_hits;

    function new();
      primed   = 0;
      pos_est  = 0;
      vel_est  = 0;
      cov[0]   = 1 << COV_FRAC_BITS;
      cov[1]   = 0;
      cov[2]   = 0;
      cov[3]   = 1 << COV_FRAC_BITS;
      q_noise  = PROCESS_NOISE_RESET;
      r_noise  = MEASUREMENT_NOISE_RESET;
    endfunction

    function int clamp(longint v);
      if (v > 64'sh7fffffff) return 32'sh7fffffff;
      if (v < -64'sh80000000) return 32'sh80000000;
      return int'(v);
    endfunction

    // Gain times value in Q8.24, rounded to nearest with ties upward.
    function longint gain_mul(int g, int v);
      longint p;
      p = longint'(g) * longint'(v);
      return (p + (64'sd1 <<< (COV_FRAC_BITS - 1))) >>> COV_FRAC_BITS;
    endfunction

    function int gain_div(int num, longint den);
      if (den == 0) return 0;
      return clamp((longint'(num) <<< COV_FRAC_BITS) / den);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
      if (idx == REG_PROCESS_NOISE) q_noise = int'(val);
      else if (idx == REG_MEASUREMENT_NOISE) r_noise = int'(val);
    endfunction

    // Runs one filter update for an accepted sample.
    function void note_sample(int z);
      int     xp0, xp1, p00, p01, p10, p11, k0, k1, innov;
      longint div_den;
      samples_seen++;
      if (!primed) begin
        pos_est = z;
        vel_est = 0;
        primed  = 1;
      end else begin
        xp0 = clamp(longint'(pos_est) + vel_est);
        xp1 = vel_est;
        p00 = clamp(longint'(cov[0]) + cov[1] + cov[2] + cov[3] + q_noise);
        p01 = clamp(longint'(cov[1]) + cov[3]);
        p10 = clamp(longint'(cov[2]) + cov[3]);
        p11 = clamp(longint'(cov[3]) + q_noise);
        div_den = longint'(p00) + r_noise;
        if (div_den == 0) zero_div_hits++;
        k0 = gain_div(p00, div_den);
        k1 = gain_div(p10, div_den);
        innov = clamp(longint'(z) - xp0);
        pos_est = clamp(longint'(xp0) + gain_mul(k0, innov));
        vel_est = clamp(longint'(xp1) + gain_mul(k1, innov));
        cov[0]  = clamp(longint'(p00) - gain_mul(k0, p00));
        cov[1]  = clamp(longint'(p01) - gain_mul(k0, p01));
        cov[2]  = clamp(longint'(p10) - gain_mul(k1, p00));
        cov[3]  = clamp(longint'(p11) - gain_mul(k1, p01));
      end
      expected_pos.push_back(pos_est);
    endfunction

    function void check_position(logic signed [DATA_W-1:0] got);
      int want;
      results_seen++;
      if (expected_pos.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected filtered_position %0d", $time, got);
        return;
      end
      want = expected_pos.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: filtered_position expected %0d actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NOISE_W-1:0]   cfg_data;

  cvkf_sample_if   smp ();
  cvkf_estimate_if est ();

  position_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int cfg_writes;
  int idle_cycles;

  constant_velocity_kalman_filter dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp.sink),
    .estimates (est.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    smp.valid        = 1'b0;
    smp.range_sample = '0;
    est.ready        = 1'b0;
  end

  // Receiver side: random stalls on the estimate channel.
  always @(posedge clk) begin
    if (rst) begin
      est.ready <= 1'b0;
    end else begin
      est.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitors on both channels; values are those before the edge.
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (smp.valid && smp.ready) sb.note_sample(smp.range_sample);
      if (est.valid && est.ready) sb.check_position(est.filtered_position);
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (est.valid && est.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Drives one sample, with random gaps ahead of it.
  task automatic send_sample(logic signed [DATA_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid        <= 1'b1;
    smp.range_sample <= z;
    do @(posedge clk); while (!smp.ready);
  endtask

  // Holds the sender off until every expected position has come back.
  // It waits first so that the monitor has noted the last transfer.
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pos.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes both noise registers plus an unused index, with the block idle.
  task automatic set_noise(logic [NOISE_W-1:0] q, logic [NOISE_W-1:0] r);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [NOISE_W-1:0]   val [3];
    drain();
    idx[0] = REG_PROCESS_NOISE;
    idx[1] = REG_MEASUREMENT_NOISE;
    idx[2] = CFG_IDX_W'($urandom_range(2, 3));
    val[0] = q;
    val[1] = r;
    val[2] = NOISE_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
      cfg_writes++;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random part: mostly a moving target with noise, some wild samples.
  task automatic random_phase(int count, int idle_pct, int stall_pct);
    int track_pos;
    int track_vel;
    int pick;
    logic signed [DATA_W-1:0] z;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    track_pos = $urandom_range(65536 * 200);
    track_vel = int'($urandom_range(65536 * 2)) - 65536;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      track_pos += track_vel;
      if (pick < 80) begin
        z = track_pos + int'($urandom_range(32768)) - 16384;
      end else if (pick < 92) begin
        z = $urandom;
      end else if (pick < 96) begin
        z = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        z = {1'b1, {(DATA_W-1){1'b0}}};
      end
      send_sample(z);
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_writes     = 0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: priming sample, then extremes and innovation overflow.
    send_sample(32'sh0001_0000);
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample({1'b1, {(DATA_W-1){1'b0}}});
    send_sample({1'b0, {(DATA_W-1){1'b1}}});
    send_sample('0);
    send_sample(-32'sd1);

    // Zero noise collapses the covariance until the divisor is zero.
    set_noise('0, '0);
    for (int i = 0; i < 6; i++) send_sample(32'sh0000_4000 * i);

    // Both noise values at 1.0 with saturating samples.
    set_noise(NOISE_W'(16777216), NOISE_W'(16777216));
    for (int i = 0; i < 6; i++) begin
      send_sample(i[0] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
    end

    // Random phases under different noise settings and flow patterns.
    set_noise(PROCESS_NOISE_RESET, MEASUREMENT_NOISE_RESET);
    random_phase(310, 0, 0);
    set_noise(NOISE_W'($urandom_range(16777216)), NOISE_W'($urandom_range(16777216)));
    random_phase(310, 54, 0);
    set_noise(NOISE_W'(16777216), '0);
    random_phase(310, 0, 54);
    set_noise(NOISE_W'($urandom_range(4096)), NOISE_W'($urandom_range(1 << 20)));
    random_phase(310, 20, 20);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples, checked %0d positions, %0d register writes.",
             sb.samples_seen, sb.results_seen, cfg_writes);
    $display("Zero-divisor updates seen: %0d; mismatches: %0d.",
             sb.zero_div_hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_pos.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
